@@ sv/partitioned_bloom_filter_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the Bloom filter core.
// ----------------------------------------------------------------------------
`ifndef PARTITIONED_BLOOM_FILTER_CORE_ASSERT_SVH
`define PARTITIONED_BLOOM_FILTER_CORE_ASSERT_SVH

// same-cycle implication
`define PBF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PBF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/pbf_pkg.sv @@
// ----------------------------------------------------------------------------
// pbf_pkg
// Types, codes and hash constants of the partitioned Bloom filter.
// ----------------------------------------------------------------------------
package pbf_pkg;

	localparam logic [1:0] MODE_QUERY  = 2'd0;
	localparam logic [1:0] MODE_INSERT = 2'd1;
	localparam logic [1:0] MODE_CLEAR  = 2'd2;
	localparam logic [1:0] MODE_NONE   = 2'd3;

	localparam logic REG_NUM_HASHES = 1'b0;
	localparam logic REG_PART_LOG2  = 1'b1;

	localparam logic [63:0] SEED      = 64'h0000_0000_97c2_9b3a;
	localparam logic [63:0] MIX_C1    = 64'h87c3_7b91_1142_53d5;
	localparam logic [63:0] MIX_C2    = 64'h4cf5_ad43_2e7f_e4f5;
	localparam logic [63:0] FMIX_C1   = 64'hff51_afd7_ed55_8ccd;
	localparam logic [63:0] FMIX_C2   = 64'hc4ce_b9fe_1a85_ec53;
	localparam logic [63:0] LANE1_ADD = 64'h0000_0000_52dc_e729;
	localparam logic [63:0] LANE2_ADD = 64'h0000_0000_3849_5ab5;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;

	typedef struct packed {
		logic [1:0]  mode;
		logic [63:0] hash;
	} key_word_t;

	function automatic logic [63:0] rotl64(input logic [63:0] x, input int r);
		rotl64 = (x << r) | (x >> (64 - r));
	endfunction

	function automatic logic [63:0] fold33(input logic [63:0] x);
		fold33 = x ^ (x >> 33);
	endfunction

endpackage

@@ sv/partitioned_bloom_filter_core.sv @@
// ----------------------------------------------------------------------------
// partitioned_bloom_filter_core
// Partitioned Bloom filter keyed by a streamed MurmurHash3 x64_128 hash.
// ----------------------------------------------------------------------------
// Input queue port: push/full, one key byte per word; key_end closes a key
// and mode on that word selects query, insert, clear or none. Result queue
// port: empty/pop, one result word per key_end word, in order.
// Bytes are taken one per cycle while full is low; every sixteenth byte
// absorbs a block through the shared 32x32 multiplier, holding full. Closing
// a query or insert key holds full while the front hashes (after absorbing
// a block when the closing byte completes one), longer if the queue has no
// room; a clear or none key goes straight to the queue. The back spends a
// read and a write state per probe on the store, plus an idle and a done
// state per key, so several keys overlap between front and back through a
// four-word queue. A clear sweeps the store one 64-bit row a cycle (2048
// rows at default sizes) before its result appears. After reset the same
// sweep runs and full stays high until it ends; the register port is live
// throughout. When the receiver holds pop low the result register keeps its
// word, the back and then the queue fill and full rises; nothing is dropped.
// ----------------------------------------------------------------------------
module partitioned_bloom_filter_core #(
	parameter int MAX_HASHES          = 16,
	parameter int MAX_PART_BYTES_LOG2 = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  mode,
	input  logic [7:0]  key_byte,
	input  logic        byte_valid,
	input  logic        key_end,
	output logic        empty,
	input  logic        pop,
	output logic        present,
	output logic [4:0]  newly_set,
	output logic [31:0] entry_total,
	output logic [31:0] unique_total,
	output logic [17:0] set_bit_total,
	input  logic        wr_en,
	input  logic        wr_index,
	input  logic [4:0]  wr_data
);
	logic               front_busy, init_busy, accept, out_valid;
	logic               q_push, q_full, q_pop, q_empty;
	pbf_pkg::key_word_t q_wdata, q_rdata;
	logic [4:0]         num_hashes_q;
	logic [3:0]         part_log2_q;

	assign full   = front_busy || init_busy;
	assign accept = push && !full;
	assign empty  = !out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_hashes_q <= 5'd1;
			part_log2_q  <= 4'd1;
		end else if (wr_en) begin
			case (wr_index)
				pbf_pkg::REG_NUM_HASHES: num_hashes_q <= wr_data;
				pbf_pkg::REG_PART_LOG2:  part_log2_q  <= wr_data[3:0];
				default: num_hashes_q <= num_hashes_q;
			endcase
		end
	end

	pbf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.mode       (mode),
		.key_byte   (key_byte),
		.byte_valid (byte_valid),
		.key_end    (key_end),
		.busy       (front_busy),
		.q_push     (q_push),
		.q_word     (q_wdata),
		.q_full     (q_full)
	);

	pbf_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.rd     (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	pbf_back #(
		.MAX_HASHES          (MAX_HASHES),
		.MAX_PART_BYTES_LOG2 (MAX_PART_BYTES_LOG2)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.num_hashes    (num_hashes_q),
		.part_log2     (part_log2_q),
		.q_empty       (q_empty),
		.q_word        (q_rdata),
		.q_pop         (q_pop),
		.init_busy     (init_busy),
		.out_valid     (out_valid),
		.pop           (pop),
		.present       (present),
		.newly_set     (newly_set),
		.entry_total   (entry_total),
		.unique_total  (unique_total),
		.set_bit_total (set_bit_total)
	);

endmodule

@@ sv/pbf_mul64.sv @@
// ----------------------------------------------------------------------------
// pbf_mul64
// Low 64 bits of a 64x64 product from one 32x32 multiplier, phases LL, LH, HL.
// ----------------------------------------------------------------------------
module pbf_mul64 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        done,
	output logic [63:0] prod
);
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_LL   = 2'd1;
	localparam logic [1:0] PH_LH   = 2'd2;
	localparam logic [1:0] PH_HL   = 2'd3;

	logic [1:0]  ph_q;
	logic        done_q;
	logic [63:0] a_q, b_q, acc_q;
	logic [31:0] ma, mb;
	logic [63:0] mp;

	always_comb begin
		case (ph_q)
			PH_LH: begin
				ma = a_q[31:0];
				mb = b_q[63:32];
			end
			PH_HL: begin
				ma = a_q[63:32];
				mb = b_q[31:0];
			end
			default: begin
				ma = a_q[31:0];
				mb = b_q[31:0];
			end
		endcase
		mp = 64'(ma) * 64'(mb);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= (ph_q == PH_HL);
			case (ph_q)
				PH_IDLE: if (start) ph_q <= PH_LL;
				PH_LL:   ph_q <= PH_LH;
				PH_LH:   ph_q <= PH_HL;
				PH_HL:   ph_q <= PH_IDLE;
				default: ph_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ph_q == PH_IDLE && start) begin
			a_q <= a;
			b_q <= b;
		end
		case (ph_q)
			PH_LL:   acc_q <= mp;
			PH_LH:   acc_q <= acc_q + {mp[31:0], 32'h0};
			PH_HL:   acc_q <= acc_q + {mp[31:0], 32'h0};
			default: acc_q <= acc_q;
		endcase
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

@@ sv/pbf_front.sv @@
// ----------------------------------------------------------------------------
// pbf_front
// Key byte intake and streamed MurmurHash3 x64_128, one hash word per key.
// ----------------------------------------------------------------------------
module pbf_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [1:0]        mode,
	input  logic [7:0]        key_byte,
	input  logic              byte_valid,
	input  logic              key_end,
	output logic              busy,
	output logic              q_push,
	output pbf_pkg::key_word_t q_word,
	input  logic              q_full
);
	localparam logic [3:0] F_IDLE = 4'd0;
	localparam logic [3:0] F_K1A  = 4'd1;
	localparam logic [3:0] F_K1B  = 4'd2;
	localparam logic [3:0] F_K2A  = 4'd3;
	localparam logic [3:0] F_K2B  = 4'd4;
	localparam logic [3:0] F_FIN  = 4'd5;
	localparam logic [3:0] F_FIN2 = 4'd6;
	localparam logic [3:0] F_FM1A = 4'd7;
	localparam logic [3:0] F_FM1B = 4'd8;
	localparam logic [3:0] F_FM2A = 4'd9;
	localparam logic [3:0] F_FM2B = 4'd10;
	localparam logic [3:0] F_PUSH = 4'd11;

	logic [3:0]   fst_q;
	logic         pend_q, absorb_q, end_q;
	logic [1:0]   mode_q;
	logic [63:0]  lane1_q, lane2_q, t_q;
	logic [127:0] buf_q;
	logic [31:0]  len_q;

	logic         is_mul, mul_start, mul_done, hash_it, blk;
	logic [63:0]  mul_a, mul_b, mul_p;
	logic [63:0]  x1, x2, s1, s2, len64, l1x, l2x;

	always_comb begin
		is_mul = (fst_q == F_K1A) || (fst_q == F_K1B) || (fst_q == F_K2A) ||
			(fst_q == F_K2B) || (fst_q == F_FM1A) || (fst_q == F_FM1B) ||
			(fst_q == F_FM2A) || (fst_q == F_FM2B);
		mul_start = is_mul && !pend_q;
		case (fst_q)
			F_K1A: begin
				mul_a = buf_q[63:0];
				mul_b = pbf_pkg::MIX_C1;
			end
			F_K1B: begin
				mul_a = t_q;
				mul_b = pbf_pkg::MIX_C2;
			end
			F_K2A: begin
				mul_a = buf_q[127:64];
				mul_b = pbf_pkg::MIX_C2;
			end
			F_K2B: begin
				mul_a = t_q;
				mul_b = pbf_pkg::MIX_C1;
			end
			F_FM1A: begin
				mul_a = pbf_pkg::fold33(lane1_q);
				mul_b = pbf_pkg::FMIX_C1;
			end
			F_FM2A: begin
				mul_a = pbf_pkg::fold33(lane2_q);
				mul_b = pbf_pkg::FMIX_C1;
			end
			default: begin
				mul_a = pbf_pkg::fold33(t_q);
				mul_b = pbf_pkg::FMIX_C2;
			end
		endcase
		x1    = lane1_q ^ mul_p;
		x2    = lane2_q ^ mul_p;
		s1    = pbf_pkg::rotl64(x1, 27) + lane2_q;
		s2    = pbf_pkg::rotl64(x2, 31) + lane1_q;
		len64 = {32'h0, len_q};
		l1x   = lane1_q ^ len64;
		l2x   = lane2_q ^ len64;
		hash_it = key_end && (mode == pbf_pkg::MODE_QUERY || mode == pbf_pkg::MODE_INSERT);
		blk     = byte_valid && (len_q[3:0] == 4'hF);
	end

	pbf_mul64 u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_p)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fst_q    <= F_IDLE;
			pend_q   <= 1'b0;
			absorb_q <= 1'b0;
			end_q    <= 1'b0;
			mode_q   <= pbf_pkg::MODE_QUERY;
			lane1_q  <= pbf_pkg::SEED;
			lane2_q  <= pbf_pkg::SEED;
			buf_q    <= '0;
			len_q    <= '0;
			t_q      <= '0;
		end else begin
			if (mul_start) pend_q <= 1'b1;
			if (mul_done) pend_q <= 1'b0;
			case (fst_q)
				F_IDLE: if (accept) begin
					if (byte_valid) begin
						buf_q[{len_q[3:0], 3'b000} +: 8] <= key_byte;
						len_q <= len_q + 32'd1;
					end
					mode_q <= mode;
					if (key_end && !hash_it) begin
						fst_q <= F_PUSH;
					end else if (blk) begin
						absorb_q <= 1'b1;
						end_q    <= key_end;
						fst_q    <= F_K1A;
					end else if (key_end) begin
						absorb_q <= 1'b0;
						end_q    <= 1'b0;
						fst_q    <= F_K1A;
					end
				end
				F_K1A: if (mul_done) begin
					t_q   <= pbf_pkg::rotl64(mul_p, 31);
					fst_q <= F_K1B;
				end
				F_K1B: if (mul_done) begin
					lane1_q <= absorb_q ? (s1 << 2) + s1 + pbf_pkg::LANE1_ADD : x1;
					fst_q   <= F_K2A;
				end
				F_K2A: if (mul_done) begin
					t_q   <= pbf_pkg::rotl64(mul_p, 33);
					fst_q <= F_K2B;
				end
				F_K2B: if (mul_done) begin
					if (absorb_q) begin
						lane2_q <= (s2 << 2) + s2 + pbf_pkg::LANE2_ADD;
						buf_q   <= '0;
						if (end_q) begin
							absorb_q <= 1'b0;
							end_q    <= 1'b0;
							fst_q    <= F_K1A;
						end else begin
							fst_q <= F_IDLE;
						end
					end else begin
						lane2_q <= x2;
						fst_q   <= F_FIN;
					end
				end
				F_FIN: begin
					lane1_q <= l1x + l2x;
					lane2_q <= l2x;
					fst_q   <= F_FIN2;
				end
				F_FIN2: begin
					lane2_q <= lane2_q + lane1_q;
					fst_q   <= F_FM1A;
				end
				F_FM1A: if (mul_done) begin
					t_q   <= mul_p;
					fst_q <= F_FM1B;
				end
				F_FM1B: if (mul_done) begin
					lane1_q <= pbf_pkg::fold33(mul_p);
					fst_q   <= F_FM2A;
				end
				F_FM2A: if (mul_done) begin
					t_q   <= mul_p;
					fst_q <= F_FM2B;
				end
				F_FM2B: if (mul_done) begin
					lane2_q <= pbf_pkg::fold33(mul_p);
					fst_q   <= F_PUSH;
				end
				F_PUSH: if (!q_full) begin
					lane1_q <= pbf_pkg::SEED;
					lane2_q <= pbf_pkg::SEED;
					buf_q   <= '0;
					len_q   <= '0;
					fst_q   <= F_IDLE;
				end
				default: fst_q <= F_IDLE;
			endcase
		end
	end

	assign busy        = (fst_q != F_IDLE);
	assign q_push      = (fst_q == F_PUSH) && !q_full;
	assign q_word.mode = mode_q;
	assign q_word.hash = lane1_q + lane2_q;

endmodule

@@ sv/pbf_fifo.sv @@
// ----------------------------------------------------------------------------
// pbf_fifo
// Short queue of hashed key words between the hash front and probe back.
// ----------------------------------------------------------------------------
module pbf_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr,
	input  pbf_pkg::key_word_t wdata,
	output logic               full,
	input  logic               rd,
	output pbf_pkg::key_word_t rdata,
	output logic               empty
);
	pbf_pkg::key_word_t           ent_q [pbf_pkg::QDEPTH];
	logic [pbf_pkg::QPTR_W-1:0]   wp_q, rp_q;
	logic [pbf_pkg::QPTR_W:0]     cnt_q;
	logic                         do_wr, do_rd;

	assign full  = (cnt_q == (pbf_pkg::QPTR_W+1)'(pbf_pkg::QDEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) wp_q <= wp_q + 1'b1;
			if (do_rd) rp_q <= rp_q + 1'b1;
			if (do_wr && !do_rd) cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) ent_q[wp_q] <= wdata;
	end

endmodule

@@ sv/pbf_back.sv @@
// ----------------------------------------------------------------------------
// pbf_back
// Probe engine: read-modify-write of the partitioned bit store, counters,
// clearing pass and result register.
// ----------------------------------------------------------------------------
`include "partitioned_bloom_filter_core_assert.svh"

module pbf_back #(
	parameter int MAX_HASHES          = 16,
	parameter int MAX_PART_BYTES_LOG2 = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [4:0]         num_hashes,
	input  logic [3:0]         part_log2,
	input  logic               q_empty,
	input  pbf_pkg::key_word_t q_word,
	output logic               q_pop,
	output logic               init_busy,
	output logic               out_valid,
	input  logic               pop,
	output logic               present,
	output logic [4:0]         newly_set,
	output logic [31:0]        entry_total,
	output logic [31:0]        unique_total,
	output logic [17:0]        set_bit_total
);
	localparam int OFF_W    = MAX_PART_BYTES_LOG2 + 3;
	localparam int ADDR_W   = $clog2(MAX_HASHES) + OFF_W;
	localparam int ROW_LOG2 = (ADDR_W < 7) ? ADDR_W - 1 : 6;
	localparam int ROW_W    = ADDR_W - ROW_LOG2;
	localparam int ROWS     = 2 ** ROW_W;
	localparam int ROW_BITS = 2 ** ROW_LOG2;
	localparam int IW       = $clog2(MAX_HASHES + 1);
	localparam int PLW      = $clog2(MAX_PART_BYTES_LOG2 + 1);

	localparam logic [2:0] B_IDLE = 3'd0;
	localparam logic [2:0] B_CLR  = 3'd1;
	localparam logic [2:0] B_RD   = 3'd2;
	localparam logic [2:0] B_WR   = 3'd3;
	localparam logic [2:0] B_DONE = 3'd4;

	logic [ROW_BITS-1:0] mem [ROWS];
	logic [ROW_BITS-1:0] rdata_q, mem_wdata;
	logic [ROW_W-1:0]    mem_raddr, mem_waddr, clr_q, row_q;
	logic                mem_we;

	logic [2:0]          bst_q;
	logic                init_q, present_q;
	logic [1:0]          mode_q;
	logic [IW-1:0]       i_q, fresh_q, nh_c;
	logic [31:0]         k_q, p2_q;
	logic [ROW_LOG2-1:0] bsel_q;
	logic [31:0]         cnt_ins_q, cnt_uni_q;
	logic [17:0]         cnt_den_q;

	logic                o_valid_q, o_present_q;
	logic [4:0]          o_fresh_q;
	logic [31:0]         o_ins_q, o_uni_q;
	logic [17:0]         o_den_q;

	logic [PLW-1:0]      pl_c;
	logic [PLW:0]        sh;
	logic [OFF_W-1:0]    pmask, off;
	logic [ADDR_W-1:0]   addr;
	logic                is_ins, load_out, hit;
	logic [18:0]         den_sum;
	logic [17:0]         den_new;
	logic [31:0]         ins_new, uni_new;

	always_comb begin
		nh_c  = (32'(num_hashes) > MAX_HASHES) ? IW'(MAX_HASHES) : IW'(num_hashes);
		pl_c  = (32'(part_log2) > MAX_PART_BYTES_LOG2) ?
			PLW'(MAX_PART_BYTES_LOG2) : PLW'(part_log2);
		sh    = (PLW+1)'(pl_c) + (PLW+1)'(3);
		pmask = (OFF_W'(8) << pl_c) - OFF_W'(1);
		off   = k_q[OFF_W-1:0] & pmask;
		addr  = (ADDR_W'(i_q) << sh) | ADDR_W'(off);
		is_ins = (mode_q == pbf_pkg::MODE_INSERT);
		hit    = rdata_q[bsel_q];
		load_out = (bst_q == B_DONE) && (!o_valid_q || pop);
		den_sum = {1'b0, cnt_den_q} + 19'(fresh_q);
		den_new = den_sum[18] ? 18'h3FFFF : den_sum[17:0];
		ins_new = (cnt_ins_q == 32'hFFFF_FFFF) ? cnt_ins_q : cnt_ins_q + 32'd1;
		uni_new = ((fresh_q != '0) && (cnt_uni_q != 32'hFFFF_FFFF)) ?
			cnt_uni_q + 32'd1 : cnt_uni_q;
		mem_raddr = addr[ADDR_W-1:ROW_LOG2];
		mem_we    = 1'b0;
		mem_waddr = row_q;
		mem_wdata = rdata_q | (ROW_BITS'(1) << bsel_q);
		if (bst_q == B_CLR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = '0;
		end else if (bst_q == B_WR && !hit && is_ins) begin
			mem_we = 1'b1;
		end
	end

	assign q_pop = (bst_q == B_IDLE) && !q_empty;

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		rdata_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bst_q       <= B_CLR;
			init_q      <= 1'b1;
			clr_q       <= '0;
			mode_q      <= pbf_pkg::MODE_QUERY;
			present_q   <= 1'b0;
			fresh_q     <= '0;
			i_q         <= '0;
			k_q         <= '0;
			p2_q        <= '0;
			row_q       <= '0;
			bsel_q      <= '0;
			cnt_ins_q   <= '0;
			cnt_uni_q   <= '0;
			cnt_den_q   <= '0;
			o_valid_q   <= 1'b0;
			o_present_q <= 1'b0;
			o_fresh_q   <= '0;
			o_ins_q     <= '0;
			o_uni_q     <= '0;
			o_den_q     <= '0;
		end else begin
			if (pop && o_valid_q && !load_out) o_valid_q <= 1'b0;
			case (bst_q)
				B_IDLE: if (q_pop) begin
					mode_q    <= q_word.mode;
					present_q <= 1'b0;
					fresh_q   <= '0;
					i_q       <= '0;
					case (q_word.mode)
						pbf_pkg::MODE_CLEAR: begin
							clr_q <= '0;
							bst_q <= B_CLR;
						end
						pbf_pkg::MODE_NONE: bst_q <= B_DONE;
						default: begin
							k_q       <= q_word.hash[31:0];
							p2_q      <= q_word.hash[63:32];
							present_q <= 1'b1;
							bst_q     <= (nh_c == '0) ? B_DONE : B_RD;
						end
					endcase
				end
				B_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ROW_W'(ROWS - 1)) begin
						if (init_q) begin
							init_q <= 1'b0;
							bst_q  <= B_IDLE;
						end else begin
							cnt_ins_q <= '0;
							cnt_uni_q <= '0;
							cnt_den_q <= '0;
							bst_q     <= B_DONE;
						end
					end
				end
				B_RD: begin
					row_q  <= addr[ADDR_W-1:ROW_LOG2];
					bsel_q <= addr[ROW_LOG2-1:0];
					bst_q  <= B_WR;
				end
				B_WR: begin
					if (!hit) begin
						present_q <= 1'b0;
						if (is_ins) fresh_q <= fresh_q + 1'b1;
					end
					i_q   <= i_q + 1'b1;
					k_q   <= k_q + p2_q;
					bst_q <= (i_q + 1'b1 == nh_c) ? B_DONE : B_RD;
				end
				B_DONE: if (load_out) begin
					o_valid_q   <= 1'b1;
					o_present_q <= present_q && (mode_q == pbf_pkg::MODE_QUERY);
					o_fresh_q   <= 5'(fresh_q);
					if (is_ins) begin
						cnt_ins_q <= ins_new;
						cnt_uni_q <= uni_new;
						cnt_den_q <= den_new;
						o_ins_q   <= ins_new;
						o_uni_q   <= uni_new;
						o_den_q   <= den_new;
					end else begin
						o_ins_q <= cnt_ins_q;
						o_uni_q <= cnt_uni_q;
						o_den_q <= cnt_den_q;
					end
					bst_q <= B_IDLE;
				end
				default: bst_q <= B_IDLE;
			endcase
		end
	end

	assign init_busy     = init_q;
	assign out_valid     = o_valid_q;
	assign present       = o_present_q;
	assign newly_set     = o_fresh_q;
	assign entry_total   = o_ins_q;
	assign unique_total  = o_uni_q;
	assign set_bit_total = o_den_q;

	`PBF_ASSERT_NXT(a_rd_then_wr, clk, arst_n, bst_q == B_RD, bst_q == B_WR, "read not followed by write")
	`PBF_ASSERT_IMP(a_fresh_bound, clk, arst_n, bst_q == B_WR, fresh_q <= i_q, "new bits exceed probes")
	`PBF_ASSERT_NXT(a_out_hold, clk, arst_n, o_valid_q && !pop, o_valid_q && $stable(o_ins_q), "result word lost")

endmodule

@@ tb/sv/tb_partitioned_bloom_filter_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_partitioned_bloom_filter_core
// Self-checking bench for the partitioned Bloom filter core: streams keys one
// byte per word through the push/full port, predicts every result with an
// in-bench hash and bit store, and checks each popped word against the prediction.
// ----------------------------------------------------------------------------
module tb_partitioned_bloom_filter_core;

	localparam int NH_CAP   = 16;
	localparam int PL_CAP   = 10;
	localparam int STORE_SZ = NH_CAP << (PL_CAP + 3);
	localparam int LIMIT    = 1500000;

	typedef struct packed {
		logic        present;
		logic [4:0]  newly_set;
		logic [31:0] entry_total;
		logic [31:0] unique_total;
		logic [17:0] set_bit_total;
	} result_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] key_byte;
		logic       byte_valid;
		logic       key_end;
	} word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic [1:0] mode = pbf_pkg::MODE_QUERY;
	logic [7:0] key_byte = 8'd0;
	logic byte_valid = 1'b0;
	logic key_end = 1'b0;
	logic empty;
	logic pop = 1'b0;
	logic present;
	logic [4:0] newly_set;
	logic [31:0] entry_total;
	logic [31:0] unique_total;
	logic [17:0] set_bit_total;
	logic wr_en = 1'b0;
	logic wr_index = pbf_pkg::REG_NUM_HASHES;
	logic [4:0] wr_data = 5'd0;

	partitioned_bloom_filter_core u_top (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor state
	bit          filter_bits [STORE_SZ];
	logic [63:0] lane_a, lane_b;
	logic [7:0]  blk [16];
	logic [31:0] key_len;
	logic [31:0] n_insert, n_unique;
	logic [17:0] n_density;
	logic [4:0]  cfg_hashes;
	logic [3:0]  cfg_part_log2;

	result_t awaited_results[$];
	int errors = 0, mismatches = 0, results_seen = 0, keys_sent = 0;
	int cycles = 0;
	int pop_gap = 0;
	bit hold_off = 1'b0, no_idle = 1'b0;

	function automatic logic [63:0] rl(logic [63:0] x, int r);
		return (x << r) | (x >> (64 - r));
	endfunction

	function automatic logic [63:0] fin_mix(logic [63:0] k);
		k = k ^ (k >> 33);
		k = k * 64'hff51afd7ed558ccd;
		k = k ^ (k >> 33);
		k = k * 64'hc4ceb9fe1a85ec53;
		return k ^ (k >> 33);
	endfunction

	function automatic logic [63:0] blk_le(int from, int count);
		logic [63:0] v;
		v = '0;
		for (int b = 0; b < count; b++)
			v |= 64'(blk[(from + b) & 15]) << (8 * b);
		return v;
	endfunction

	function automatic void reset_hash();
		lane_a = 64'h97c29b3a;
		lane_b = 64'h97c29b3a;
		foreach (blk[i]) blk[i] = 8'd0;
		key_len = 32'd0;
	endfunction

	function automatic void absorb();
		logic [63:0] k1, k2;
		k1 = blk_le(0, 8);
		k2 = blk_le(8, 8);
		k1 = rl(k1 * 64'h87c37b91114253d5, 31) * 64'h4cf5ad432e7fe4f5;
		lane_a = rl(lane_a ^ k1, 27) + lane_b;
		lane_a = lane_a * 5 + 64'h52dce729;
		k2 = rl(k2 * 64'h4cf5ad432e7fe4f5, 33) * 64'h87c37b91114253d5;
		lane_b = rl(lane_b ^ k2, 31) + lane_a;
		lane_b = lane_b * 5 + 64'h38495ab5;
		foreach (blk[i]) blk[i] = 8'd0;
	endfunction

	function automatic logic [63:0] key_digest();
		int tail;
		logic [63:0] h1, h2, k;
		tail = key_len & 15;
		h1 = lane_a;
		h2 = lane_b;
		if (tail > 8) begin
			k = blk_le(8, tail - 8);
			h2 ^= rl(k * 64'h4cf5ad432e7fe4f5, 33) * 64'h87c37b91114253d5;
		end
		if (tail > 0) begin
			k = blk_le(0, tail > 8 ? 8 : tail);
			h1 ^= rl(k * 64'h87c37b91114253d5, 31) * 64'h4cf5ad432e7fe4f5;
		end
		h1 ^= 64'(key_len);
		h2 ^= 64'(key_len);
		h1 += h2;
		h2 += h1;
		h1 = fin_mix(h1);
		h2 = fin_mix(h2);
		return h1 + h2;
	endfunction

	function automatic void wipe_filter();
		foreach (filter_bits[i]) filter_bits[i] = 1'b0;
		n_insert = '0;
		n_unique = '0;
		n_density = '0;
	endfunction

	function automatic bit predict_word(word_t w, output result_t r);
		logic [63:0] h;
		logic [31:0] p1, p2, k;
		int nh, pl, addr, fresh;
		bit hit;
		r = '0;
		if (w.byte_valid) begin
			blk[key_len & 15] = w.key_byte;
			key_len++;
			if ((key_len & 15) == 0) absorb();
		end
		if (!w.key_end) return 1'b0;
		fresh = 0;
		hit = 1'b0;
		if (w.mode == pbf_pkg::MODE_CLEAR) begin
			wipe_filter();
		end else if (w.mode != pbf_pkg::MODE_NONE) begin
			h = key_digest();
			p1 = h[31:0];
			p2 = h[63:32];
			nh = cfg_hashes > NH_CAP ? NH_CAP : cfg_hashes;
			pl = cfg_part_log2 > PL_CAP ? PL_CAP : cfg_part_log2;
			hit = 1'b1;
			for (int i = 0; i < nh; i++) begin
				k = p1 + 32'(i) * p2;
				addr = (i << (pl + 3)) | (k & ((32'd8 << pl) - 1));
				if (!filter_bits[addr]) begin
					hit = 1'b0;
					if (w.mode == pbf_pkg::MODE_INSERT) begin
						filter_bits[addr] = 1'b1;
						fresh++;
					end
				end
			end
			if (w.mode == pbf_pkg::MODE_INSERT) begin
				hit = 1'b0;
				n_density = (int'(n_density) + fresh > 18'h3FFFF) ? 18'h3FFFF
					: n_density + 18'(fresh);
				if (fresh != 0 && n_unique != '1) n_unique++;
				if (n_insert != '1) n_insert++;
			end
		end
		reset_hash();
		r.present = hit;
		r.newly_set = 5'(fresh);
		r.entry_total = n_insert;
		r.unique_total = n_unique;
		r.set_bit_total = n_density;
		return 1'b1;
	endfunction

	// push stays high between back-to-back words; it drops only for idling or a drain
	task automatic send_word(word_t w);
		result_t r;
		if (!no_idle && $urandom_range(0, 5) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		push <= 1'b1;
		{mode, key_byte, byte_valid, key_end} <= w;
		do @(posedge clk); while (full);
		if (predict_word(w, r)) begin
			awaited_results.push_back(r);
			keys_sent++;
		end
	endtask

	task automatic send_key(logic [1:0] m, int len);
		word_t w;
		for (int i = 0; i < len; i++) begin
			w.mode = $urandom_range(0, 3);
			w.key_byte = $urandom;
			w.byte_valid = 1'b1;
			w.key_end = (i == len - 1);
			if (w.key_end) w.mode = m;
			if (!w.key_end && $urandom_range(0, 15) == 0) begin
				w.byte_valid = 1'b0;
				send_word(w);
				w.byte_valid = 1'b1;
			end
			send_word(w);
		end
		if (len == 0) send_word('{m, 8'($urandom), 1'b0, 1'b1});
	endtask

	task automatic drain();
		push <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [4:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		@(posedge clk);
		if (idx == pbf_pkg::REG_NUM_HASHES) cfg_hashes = val;
		else cfg_part_log2 = val[3:0];
	endtask

	// result side
	always @(posedge clk) begin
		result_t want, got;
		if (arst_n && pop && !empty) begin
			got = {present, newly_set, entry_total, unique_total, set_bit_total};
			results_seen++;
			if (awaited_results.size() == 0) begin
				errors++;
				if (mismatches++ < 10) $display("unexpected result word %h", got);
			end else begin
				want = awaited_results.pop_front();
				if (got !== want) begin
					errors++;
					if (mismatches++ < 10)
						$display("mismatch: exp %h got %h", want, got);
				end
			end
		end
		if (hold_off) begin
			pop <= 1'b0;
		end else if (pop_gap != 0) begin
			pop_gap--;
			pop <= 1'b0;
		end else if (!no_idle && $urandom_range(0, 7) == 0) begin
			pop_gap = $urandom_range(0, 4);
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// directed rows: mode, length; expected fields only where obvious
	typedef struct {
		logic [1:0] m;
		int len;
		bit fixed;
		result_t r;
	} row_t;

	row_t rows[] = '{
		'{pbf_pkg::MODE_QUERY, 0, 1'b0, '0},
		'{pbf_pkg::MODE_QUERY, 3, 1'b0, '0},
		'{pbf_pkg::MODE_CLEAR, 0, 1'b1, '0},
		'{pbf_pkg::MODE_INSERT, 0, 1'b0, '0},
		'{pbf_pkg::MODE_QUERY, 0, 1'b0, '0},
		'{pbf_pkg::MODE_INSERT, 1, 1'b0, '0},
		'{pbf_pkg::MODE_INSERT, 8, 1'b0, '0},
		'{pbf_pkg::MODE_INSERT, 9, 1'b0, '0},
		'{pbf_pkg::MODE_INSERT, 15, 1'b0, '0},
		'{pbf_pkg::MODE_INSERT, 16, 1'b0, '0},
		'{pbf_pkg::MODE_INSERT, 17, 1'b0, '0},
		'{pbf_pkg::MODE_INSERT, 33, 1'b0, '0},
		'{pbf_pkg::MODE_NONE, 5, 1'b0, '0},
		'{pbf_pkg::MODE_QUERY, 9, 1'b0, '0},
		'{pbf_pkg::MODE_CLEAR, 4, 1'b1, '0}
	};

	initial begin
		result_t exp_r;
		int pl_pick, nh_pick;
		reset_hash();
		wipe_filter();
		cfg_hashes = 5'd1;
		cfg_part_log2 = 4'd1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			send_key(rows[i].m, rows[i].len);
			if (rows[i].fixed) begin
				exp_r = awaited_results[$];
				if (exp_r !== rows[i].r) begin
					errors++;
					$display("directed row %0d: predictor gives %h", i, exp_r);
				end
			end
		end
		drain();

		// extremes of geometry, including zero probes and out-of-range values
		write_reg(pbf_pkg::REG_NUM_HASHES, 5'd0);
		write_reg(pbf_pkg::REG_PART_LOG2, 5'd0);
		send_key(pbf_pkg::MODE_INSERT, 4);
		send_key(pbf_pkg::MODE_QUERY, 2);
		drain();
		write_reg(pbf_pkg::REG_NUM_HASHES, 5'd31);
		write_reg(pbf_pkg::REG_PART_LOG2, 5'd15);
		for (int i = 0; i < 4; i++) send_key(pbf_pkg::MODE_INSERT, $urandom_range(0, 20));
		send_key(pbf_pkg::MODE_QUERY, 3);
		drain();

		// fill the result path while the receiver stalls
		fork
			begin
				hold_off = 1'b1;
				repeat (1500) @(posedge clk);
				hold_off = 1'b0;
			end
			for (int i = 0; i < 12; i++)
				send_key(pbf_pkg::MODE_INSERT, $urandom_range(1, 6));
		join
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			nh_pick = (ph == 0) ? 16 : (ph == 1) ? 1 : $urandom_range(0, 31);
			pl_pick = (ph == 0) ? 10 : (ph == 1) ? 1 : $urandom_range(0, 6);
			write_reg(pbf_pkg::REG_NUM_HASHES, 5'(nh_pick));
			write_reg(pbf_pkg::REG_PART_LOG2, 5'(pl_pick));
			if (ph == 5) no_idle = 1'b1;
			for (int k = 0; k < 45; k++) begin
				case ($urandom_range(0, 19))
					0: send_key(pbf_pkg::MODE_CLEAR, $urandom_range(0, 2));
					1: send_key(pbf_pkg::MODE_NONE, $urandom_range(0, 5));
					2, 3, 4, 5, 6, 7: send_key(pbf_pkg::MODE_QUERY, $urandom_range(0, 6));
					default: send_key(pbf_pkg::MODE_INSERT, $urandom_range(0, 6));
				endcase
			end
			drain();
		end

		$display("%0d keys checked over several filter geometries, %0d results popped",
			keys_sent, results_seen);
		if (errors == 0 && awaited_results.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d mismatches, %0d results outstanding", mismatches,
				awaited_results.size());
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
